// ===== design/kvgr_pkg.sv =====
`timescale 1ns / 1ps
// kvgr_pkg: shared types and constants of the get response parser
// no dependencies

package kvgr_pkg;

  typedef enum logic [3:0] {
    PH_PREFIX = 4'd0,
    PH_KEY    = 4'd1,
    PH_FLAGS  = 4'd2,
    PH_SIZE   = 4'd3,
    PH_LF     = 4'd4,
    PH_DATA   = 4'd5,
    PH_TRAIL  = 4'd6,
    PH_END    = 4'd7
  } phase_t;

  typedef logic [1:0] kind_t;
  typedef logic [2:0] status_t;

  localparam kind_t K_NONE = 2'd0;
  localparam kind_t K_DATA = 2'd1;
  localparam kind_t K_DONE = 2'd2;
  localparam kind_t K_ERR  = 2'd3;

  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_KEYLONG  = 3'd1;
  localparam status_t ST_DIGIT    = 3'd2;
  localparam status_t ST_LITERAL  = 3'd3;
  localparam status_t ST_OVERFLOW = 3'd4;

  localparam int NUM_W   = 31;
  localparam int BYTE_W  = 8;
  localparam int LIT_IDX_W = 3;

  localparam logic [7:0] KEY_LEN_RESET = 8'd128;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  localparam int VALUE_LEN = 6;
  localparam int END_LEN   = 5;

  localparam logic [7:0] LIT_VALUE [VALUE_LEN] = '{8'h56, 8'h41, 8'h4c, 8'h55, 8'h45, 8'h20};
  localparam logic [7:0] LIT_END   [END_LEN]   = '{8'h45, 8'h4e, 8'h44, 8'h0d, 8'h0a};

endpackage

// ===== design/kv_get_response_parser.sv =====
`timescale 1ns / 1ps
// kv_get_response_parser: the result of an accepted byte is registered and shown in the cycle after it,
// 1 byte per cycle while the output is not stalled; every byte gives exactly one result
// the parser state updates at the accept edge, the result sits in one output register
// synchronous active-low reset: parser back to the prefix, max_key_len = 128, no result held
// depends on kvgr_pkg

module kv_get_response_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [7:0]            cfg_max_key_len,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_rx_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output kvgr_pkg::kind_t       out_kind,
  output logic [7:0]            out_payload_byte,
  output logic [30:0]           out_item_size,
  output logic [30:0]           out_item_flags,
  output kvgr_pkg::status_t     out_status
);
  import kvgr_pkg::*;

  phase_t                 phase_r, phase_nxt;
  logic [LIT_IDX_W-1:0]   lit_idx_r, lit_idx_nxt;
  logic [7:0]             key_count_r, key_count_nxt;
  logic [NUM_W-1:0]       flags_r, flags_nxt;
  logic [NUM_W-1:0]       size_r, size_nxt;
  logic [NUM_W-1:0]       left_r, left_nxt;
  logic [7:0]             max_key_len_r;

  logic                   out_valid_r, out_valid_nxt;
  kind_t                  kind_r, kind_nxt;
  logic [7:0]             data_r, data_nxt;
  logic [NUM_W-1:0]       osize_r, oflags_r;
  status_t                status_r, status_nxt;

  logic                   in_acc;
  logic                   is_digit;
  logic [3:0]             digit_val;
  logic [NUM_W+3:0]       flags_x10, size_x10;
  logic                   flags_ovf, size_ovf;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;

  assign is_digit  = (in_rx_byte >= CH_ZERO) && (in_rx_byte <= CH_NINE);
  assign digit_val = 4'(in_rx_byte - CH_ZERO);

  // acc * 10 + digit, overflow when any bit from bit 31 up is set
  assign flags_x10 = {1'b0, flags_r, 3'b000} + {3'b000, flags_r, 1'b0}
                     + {(NUM_W)'(0), digit_val};
  assign size_x10  = {1'b0, size_r, 3'b000} + {3'b000, size_r, 1'b0}
                     + {(NUM_W)'(0), digit_val};
  assign flags_ovf = |flags_x10[NUM_W+3:NUM_W];
  assign size_ovf  = |size_x10[NUM_W+3:NUM_W];

  always_comb begin
    phase_nxt     = phase_r;
    lit_idx_nxt   = lit_idx_r;
    key_count_nxt = key_count_r;
    flags_nxt     = flags_r;
    size_nxt      = size_r;
    left_nxt      = left_r;
    kind_nxt      = K_NONE;
    data_nxt      = 8'd0;
    status_nxt    = ST_OK;

    unique case (phase_r)
      PH_PREFIX: begin
        if (lit_idx_r < LIT_IDX_W'(VALUE_LEN) && LIT_VALUE[lit_idx_r] == in_rx_byte) begin
          if (lit_idx_r == LIT_IDX_W'(VALUE_LEN - 1)) begin
            lit_idx_nxt = '0;
            phase_nxt   = PH_KEY;
          end else begin
            lit_idx_nxt = lit_idx_r + 1'b1;
          end
        end else begin
          kind_nxt   = K_ERR;
          status_nxt = ST_LITERAL;
        end
      end
      PH_KEY: begin
        if (in_rx_byte == CH_SPACE) begin
          phase_nxt = PH_FLAGS;
        end else if (key_count_r >= max_key_len_r) begin
          kind_nxt   = K_ERR;
          status_nxt = ST_KEYLONG;
        end else begin
          key_count_nxt = key_count_r + 1'b1;
        end
      end
      PH_FLAGS: begin
        if (is_digit) begin
          if (flags_ovf) begin
            kind_nxt   = K_ERR;
            status_nxt = ST_OVERFLOW;
          end else begin
            flags_nxt = flags_x10[NUM_W-1:0];
          end
        end else if (in_rx_byte == CH_SPACE) begin
          phase_nxt = PH_SIZE;
        end else begin
          kind_nxt   = K_ERR;
          status_nxt = ST_DIGIT;
        end
      end
      PH_SIZE: begin
        if (is_digit) begin
          if (size_ovf) begin
            kind_nxt   = K_ERR;
            status_nxt = ST_OVERFLOW;
          end else begin
            size_nxt = size_x10[NUM_W-1:0];
          end
        end else if (in_rx_byte == CH_CR) begin
          phase_nxt = PH_LF;
        end else begin
          kind_nxt   = K_ERR;
          status_nxt = ST_DIGIT;
        end
      end
      PH_LF: begin
        // byte after the CR is not checked
        left_nxt    = size_r;
        phase_nxt   = (size_r == '0) ? PH_TRAIL : PH_DATA;
        lit_idx_nxt = '0;
      end
      PH_DATA: begin
        kind_nxt = K_DATA;
        data_nxt = in_rx_byte;
        if (left_r <= NUM_W'(1)) begin
          left_nxt    = '0;
          phase_nxt   = PH_TRAIL;
          lit_idx_nxt = '0;
        end else begin
          left_nxt = left_r - 1'b1;
        end
      end
      PH_TRAIL: begin
        if (lit_idx_r == '0 && in_rx_byte == CH_CR) begin
          lit_idx_nxt = LIT_IDX_W'(1);
        end else if (lit_idx_r == LIT_IDX_W'(1) && in_rx_byte == CH_LF) begin
          lit_idx_nxt = '0;
          phase_nxt   = PH_END;
        end else begin
          kind_nxt   = K_ERR;
          status_nxt = ST_LITERAL;
        end
      end
      PH_END: begin
        if (lit_idx_r < LIT_IDX_W'(END_LEN) && LIT_END[lit_idx_r] == in_rx_byte) begin
          if (lit_idx_r == LIT_IDX_W'(END_LEN - 1)) begin
            lit_idx_nxt = '0;
            kind_nxt    = K_DONE;
          end else begin
            lit_idx_nxt = lit_idx_r + 1'b1;
          end
        end else begin
          kind_nxt   = K_ERR;
          status_nxt = ST_LITERAL;
        end
      end
      default: begin
        phase_nxt     = PH_PREFIX;
        lit_idx_nxt   = '0;
        key_count_nxt = '0;
        flags_nxt     = '0;
        size_nxt      = '0;
        left_nxt      = '0;
      end
    endcase
  end

  always_comb begin
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_PREFIX;
      lit_idx_r     <= '0;
      key_count_r   <= '0;
      flags_r       <= '0;
      size_r        <= '0;
      left_r        <= '0;
      max_key_len_r <= KEY_LEN_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_key_len_r <= cfg_max_key_len;
      end
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        // done and error go back to the start with cleared state
        if (kind_nxt == K_DONE || kind_nxt == K_ERR) begin
          phase_r     <= PH_PREFIX;
          lit_idx_r   <= '0;
          key_count_r <= '0;
          flags_r     <= '0;
          size_r      <= '0;
          left_r      <= '0;
        end else begin
          phase_r     <= phase_nxt;
          lit_idx_r   <= lit_idx_nxt;
          key_count_r <= key_count_nxt;
          flags_r     <= flags_nxt;
          size_r      <= size_nxt;
          left_r      <= left_nxt;
        end
      end
    end
  end

  // result register, all result fields but valid
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r   <= kind_nxt;
      data_r   <= data_nxt;
      osize_r  <= size_nxt;
      oflags_r <= flags_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_payload_byte = data_r;
  assign out_item_size    = osize_r;
  assign out_item_flags   = oflags_r;
  assign out_status       = status_r;

endmodule

// ===== design/kvgr_checker.sv =====
`timescale 1ns / 1ps
// kvgr_checker: port-level checks of the get response parser, bound into kv_get_response_parser
// depends on kvgr_pkg and kv_get_response_parser

module kvgr_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input kvgr_pkg::kind_t      out_kind,
  input logic [7:0]           out_payload_byte,
  input kvgr_pkg::status_t    out_status
);
  import kvgr_pkg::*;

  // every accepted request gives a result on the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted request produced no result");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_status))
    else $error("stalled result changed");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_kind == K_ERR) == (out_status != ST_OK)))
    else $error("status disagrees with result kind");

  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != K_DATA |-> out_payload_byte == 8'd0)
    else $error("payload byte set on a non-data result");

endmodule

bind kv_get_response_parser kvgr_checker u_kvgr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_kind         (out_kind),
  .out_payload_byte (out_payload_byte),
  .out_status       (out_status)
);

// ===== dv/tb_kv_get_response_parser.sv =====
`timescale 1ns / 1ps
// tb_kv_get_response_parser: self-checking bench for the get response parser,
// a directed stimulus table then random replies, each result checked against the table or a predictor
// depends on kvgr_pkg and kv_get_response_parser

module tb_kv_get_response_parser;
  import kvgr_pkg::*;

  typedef struct packed {
    kind_t           kind;
    logic [7:0]      payload;
    logic [NUM_W-1:0] size;
    logic [NUM_W-1:0] flags;
    status_t         status;
  } parse_result_t;

  typedef struct packed {
    logic [7:0]    rx;
    logic          typed;
    parse_result_t want;
  } stim_row_t;

  localparam int              DIR_N          = 27;
  localparam int              PHASE_BYTES    = 220;
  localparam int              WATCHDOG_LIMIT = 1000;
  localparam longint unsigned NUM_LIMIT      = 64'h7fff_ffff;
  localparam parse_result_t   NO_WANT        = '0;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [7:0]       cfg_max_key_len;
  logic             in_valid;
  logic             in_stall;
  logic [7:0]       in_rx_byte;
  logic             out_valid;
  logic             out_stall;
  kind_t            out_kind;
  logic [7:0]       out_payload_byte;
  logic [NUM_W-1:0] out_item_size;
  logic [NUM_W-1:0] out_item_flags;
  status_t          out_status;

  // predictor state
  phase_t           parse_phase;
  int               lit_pos;
  logic [7:0]       key_seen;
  logic [NUM_W-1:0] flags_acc;
  logic [NUM_W-1:0] size_acc;
  logic [NUM_W-1:0] data_left;
  logic [7:0]       key_limit;

  parse_result_t    expected_q [$];
  logic [7:0]       resp_bytes [$];
  int unsigned      mismatches = 0;
  int unsigned      bytes_sent = 0;
  int unsigned      responses_sent = 0;
  int unsigned      quiet_cycles = 0;
  bit               calm = 1'b0;

  // short replies: an error on the first byte, an all-empty reply, a bad flags digit
  stim_row_t dir_rows [DIR_N] = '{
    {8'h58, 1'b1, K_ERR, 8'h00, 31'd0, 31'd0, ST_LITERAL},
    {"V", 1'b0, NO_WANT}, {"A", 1'b0, NO_WANT}, {"L", 1'b0, NO_WANT},
    {"U", 1'b0, NO_WANT}, {"E", 1'b0, NO_WANT}, {CH_SPACE, 1'b0, NO_WANT},
    {CH_SPACE, 1'b0, NO_WANT},
    {CH_SPACE, 1'b0, NO_WANT},
    {CH_CR, 1'b0, NO_WANT},
    {8'hff, 1'b0, NO_WANT},
    {CH_CR, 1'b0, NO_WANT}, {CH_LF, 1'b0, NO_WANT},
    {"E", 1'b0, NO_WANT}, {"N", 1'b0, NO_WANT}, {"D", 1'b0, NO_WANT},
    {CH_CR, 1'b0, NO_WANT},
    {CH_LF, 1'b1, K_DONE, 8'h00, 31'd0, 31'd0, ST_OK},
    {"V", 1'b0, NO_WANT}, {"A", 1'b0, NO_WANT}, {"L", 1'b0, NO_WANT},
    {"U", 1'b0, NO_WANT}, {"E", 1'b0, NO_WANT}, {CH_SPACE, 1'b0, NO_WANT},
    {CH_SPACE, 1'b0, NO_WANT},
    {"1", 1'b0, NO_WANT},
    {"x", 1'b1, K_ERR, 8'h00, 31'd0, 31'd1, ST_DIGIT}
  };

  kv_get_response_parser u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_max_key_len  (cfg_max_key_len),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_payload_byte (out_payload_byte),
    .out_item_size    (out_item_size),
    .out_item_flags   (out_item_flags),
    .out_status       (out_status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void clear_parse();
    parse_phase = PH_PREFIX;
    lit_pos = 0;
    key_seen = '0;
    flags_acc = '0;
    size_acc = '0;
    data_left = '0;
  endfunction

  function automatic parse_result_t parse_byte(input logic [7:0] b);
    parse_result_t   r;
    longint unsigned wide;
    logic            is_digit;
    r = '0;
    r.kind = K_NONE;
    r.status = ST_OK;
    is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    case (parse_phase)
      PH_PREFIX: begin
        if (b != LIT_VALUE[lit_pos]) begin
          r.kind = K_ERR;
          r.status = ST_LITERAL;
        end else if (lit_pos == VALUE_LEN - 1) begin
          lit_pos = 0;
          parse_phase = PH_KEY;
        end else begin
          lit_pos++;
        end
      end
      PH_KEY: begin
        if (b == CH_SPACE) begin
          parse_phase = PH_FLAGS;
        end else if (key_seen >= key_limit) begin
          r.kind = K_ERR;
          r.status = ST_KEYLONG;
        end else begin
          key_seen++;
        end
      end
      PH_FLAGS: begin
        if (is_digit) begin
          wide = flags_acc;
          wide = wide * 10 + (b - CH_ZERO);
          if (wide > NUM_LIMIT) begin
            r.kind = K_ERR;
            r.status = ST_OVERFLOW;
          end else begin
            flags_acc = wide[NUM_W-1:0];
          end
        end else if (b == CH_SPACE) begin
          parse_phase = PH_SIZE;
        end else begin
          r.kind = K_ERR;
          r.status = ST_DIGIT;
        end
      end
      PH_SIZE: begin
        if (is_digit) begin
          wide = size_acc;
          wide = wide * 10 + (b - CH_ZERO);
          if (wide > NUM_LIMIT) begin
            r.kind = K_ERR;
            r.status = ST_OVERFLOW;
          end else begin
            size_acc = wide[NUM_W-1:0];
          end
        end else if (b == CH_CR) begin
          parse_phase = PH_LF;
        end else begin
          r.kind = K_ERR;
          r.status = ST_DIGIT;
        end
      end
      PH_LF: begin
        // byte after the size CR is taken blindly
        data_left = size_acc;
        parse_phase = (size_acc == 0) ? PH_TRAIL : PH_DATA;
        lit_pos = 0;
      end
      PH_DATA: begin
        r.kind = K_DATA;
        r.payload = b;
        if (data_left > 0) data_left--;
        if (data_left == 0) begin
          parse_phase = PH_TRAIL;
          lit_pos = 0;
        end
      end
      PH_TRAIL: begin
        if (b != ((lit_pos == 0) ? CH_CR : CH_LF)) begin
          r.kind = K_ERR;
          r.status = ST_LITERAL;
        end else if (lit_pos == 1) begin
          lit_pos = 0;
          parse_phase = PH_END;
        end else begin
          lit_pos = 1;
        end
      end
      PH_END: begin
        if (b != LIT_END[lit_pos]) begin
          r.kind = K_ERR;
          r.status = ST_LITERAL;
        end else if (lit_pos == END_LEN - 1) begin
          lit_pos = 0;
          r.kind = K_DONE;
        end else begin
          lit_pos++;
        end
      end
      default: clear_parse();
    endcase
    r.size = size_acc;
    r.flags = flags_acc;
    if (r.kind == K_DONE || r.kind == K_ERR) clear_parse();
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void push_decimal(input longint unsigned v, input int lead);
    logic [7:0] digits [$];
    repeat (lead) resp_bytes.push_back(CH_ZERO);
    do begin
      digits.push_front(8'(CH_ZERO + v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (digits[i]) resp_bytes.push_back(digits[i]);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
    mismatches++;
  endtask

  // one request per byte; hold waits for every pending result before sending
  task automatic send_byte(input logic [7:0] b, input logic typed,
                           input parse_result_t want, input bit hold);
    int            gap;
    parse_result_t predicted;
    gap = pick_gap();
    if (hold && gap == 0) gap = 1;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      while (hold && expected_q.size() != 0) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = parse_byte(b);
    expected_q.push_back(typed ? want : predicted);
    bytes_sent++;
  endtask

  task automatic set_key_limit(input logic [7:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_max_key_len <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    key_limit = v;
  endtask

  // mostly well-formed replies with random content, some cut short or corrupted
  task automatic send_response();
    int unsigned pick;
    int unsigned key_len;
    int unsigned data_len;
    int unsigned mid;
    int          cut_at;
    logic [7:0]  b;
    resp_bytes.delete();
    cut_at = -1;
    data_len = 0;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 6)) resp_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      foreach (LIT_VALUE[i]) resp_bytes.push_back(LIT_VALUE[i]);
      pick = $urandom_range(0, 99);
      if (pick < 6) key_len = key_limit;
      else if (pick < 12) key_len = key_limit + 1;
      else key_len = $urandom_range(0, (key_limit < 10) ? key_limit : 10);
      repeat (key_len) begin
        do b = 8'($urandom_range(0, 255)); while (b == CH_SPACE);
        resp_bytes.push_back(b);
      end
      if (key_len > key_limit) cut_at = resp_bytes.size() - 1;
      resp_bytes.push_back(CH_SPACE);

      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        // no flags digits at all
      end else if (pick < 20) begin
        push_decimal(NUM_LIMIT, 0);
      end else if (pick < 26) begin
        push_decimal(NUM_LIMIT + 1 + $urandom, 0);
        if (cut_at < 0) cut_at = resp_bytes.size() - 1;
      end else if (pick < 40) begin
        push_decimal($urandom & NUM_LIMIT, 0);
      end else begin
        push_decimal($urandom_range(0, 999), $urandom_range(0, 1));
      end
      resp_bytes.push_back(CH_SPACE);

      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        // no size digits at all
      end else if (pick < 15) begin
        push_decimal(0, $urandom_range(0, 2));
      end else if (pick < 20) begin
        push_decimal(NUM_LIMIT + 1 + $urandom, 0);
        if (cut_at < 0) cut_at = resp_bytes.size() - 1;
      end else begin
        data_len = (pick < 90) ? $urandom_range(1, 6) : $urandom_range(7, 40);
        push_decimal(data_len, $urandom_range(0, 2));
      end
      resp_bytes.push_back(CH_CR);
      resp_bytes.push_back(($urandom_range(0, 1) != 0) ? CH_LF : 8'($urandom_range(0, 255)));

      repeat (data_len) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) resp_bytes.push_back(8'h00);
        else if (pick == 1) resp_bytes.push_back(8'hff);
        else resp_bytes.push_back(8'($urandom_range(0, 255)));
      end
      resp_bytes.push_back(CH_CR);
      resp_bytes.push_back(CH_LF);
      foreach (LIT_END[i]) resp_bytes.push_back(LIT_END[i]);

      if ($urandom_range(0, 99) < 12) begin
        mid = $urandom_range(0, resp_bytes.size() - 1);
        resp_bytes[mid] = 8'($urandom_range(0, 255));
        if (cut_at < 0 || mid < cut_at) cut_at = mid;
      end
      if (cut_at >= 0) resp_bytes = resp_bytes[0:cut_at];
    end

    calm = ($urandom_range(0, 9) == 0);
    mid = $urandom_range(0, resp_bytes.size() - 1);
    foreach (resp_bytes[i]) begin
      send_byte(resp_bytes[i], 1'b0, NO_WANT,
                i == mid && (responses_sent == 0 || $urandom_range(0, 9) == 0));
    end
    responses_sent++;
  endtask

  initial begin
    int unsigned run;
    int unsigned n;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      n = pick_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      run = $urandom_range(0, 6);
      repeat (run) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    parse_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result with none pending, kind", 0, out_kind);
      end else begin
        want = expected_q.pop_front();
        if (out_kind !== want.kind) report_mismatch("kind", want.kind, out_kind);
        if (out_payload_byte !== want.payload)
          report_mismatch("payload_byte", want.payload, out_payload_byte);
        if (out_item_size !== want.size)
          report_mismatch("item_size", want.size, out_item_size);
        if (out_item_flags !== want.flags)
          report_mismatch("item_flags", want.flags, out_item_flags);
        if (out_status !== want.status) report_mismatch("status", want.status, out_status);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("kv_get_response_parser regression: fail");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = '0;
    cfg_valid = 1'b0;
    cfg_max_key_len = '0;
    clear_parse();
    key_limit = KEY_LEN_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].want, 1'b0);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       set_key_limit(8'd1);
        1:       set_key_limit(8'd250);
        2:       set_key_limit(8'd7);
        default: set_key_limit(8'($urandom_range(1, 250)));
      endcase
      while (bytes_sent < DIR_N + (p + 1) * PHASE_BYTES) send_response();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("kv_get_response_parser regression: pass");
    else
      $display("kv_get_response_parser regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
design/kvgr_pkg.sv
design/kv_get_response_parser.sv
design/kvgr_checker.sv
dv/tb_kv_get_response_parser.sv
